// ----- design/mxbh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mxbh_pkg: shared definitions of the multiplicative xorshift byte hash
// widths, register codes and reset values, shift-amount helpers and the
// command bundle from controller to datapath
// ----------------------------------------------------------------------------
package mxbh_pkg;

    localparam int DATA_W      = 8;
    localparam int INDEX_W     = 32;
    localparam int VALUE_W     = 64;
    localparam int HALF_W      = VALUE_W / 2;
    localparam int TSIZE_W     = 33;
    localparam int MULT_W      = 32;
    localparam int BITS_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 33;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_COUNT  = 2'd2;

    localparam logic [TSIZE_W-1:0] TSIZE_RST = 33'd1024;
    localparam logic [MULT_W-1:0]  MULT_RST  = 32'd631;
    localparam logic [BITS_W-1:0]  BITS_RST  = 6'd10;

    // x / 3 for a 6-bit x as (x * 43) >> 7
    localparam int THIRD_RECIP = 43;
    localparam int THIRD_PROD_W = 12;
    localparam int THIRD_SHIFT = 7;

    typedef struct packed {
        logic load_byte;
        logic mul_lo;
        logic mul_hi;
        logic sum_first;
        logic sum_final;
        logic clear;
    } t_dp_cmd;

    function automatic logic [BITS_W-1:0] half_shift(input logic [BITS_W-1:0] bits);
        return {1'b0, bits[BITS_W-1:1]};
    endfunction

    function automatic logic [BITS_W-1:0] final_shift(input logic [BITS_W-1:0] bits);
        logic [THIRD_PROD_W-1:0] prod;
        prod = THIRD_PROD_W'(bits) * THIRD_PROD_W'(THIRD_RECIP);
        return bits - {1'b0, prod[THIRD_PROD_W-1:THIRD_SHIFT]};
    endfunction

    // a shift of zero clears the value
    function automatic logic [VALUE_W-1:0] xorshift(input logic [VALUE_W-1:0] v,
                                                    input logic [BITS_W-1:0] amt);
        return v ^ (v >> amt);
    endfunction

endpackage
`default_nettype wire

// ----- design/mxbh_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mxbh_ctrl: sequencing controller
// steps each byte through low product, high product and sum, runs the extra
// multiply pass on a last byte and hands the final value to the remainder unit
// ----------------------------------------------------------------------------
module mxbh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_byte,
    output logic             o_ready,
    output mxbh_pkg::t_dp_cmd o_cmd,
    output logic             o_mod_start,
    input  logic             i_mod_idle
);
    import mxbh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LO,
        S_HI,
        S_SUM,
        S_HAND
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_final, n_final;
    logic   w_accept;

    always_comb begin
        o_ready     = 1'b0;
        o_cmd       = '0;
        o_mod_start = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_LO:   o_cmd.mul_lo = 1'b1;
            S_HI:   o_cmd.mul_hi = 1'b1;
            S_SUM: begin
                o_cmd.sum_first = !r_final;
                o_cmd.sum_final = r_final;
                o_ready         = !r_last;
            end
            S_HAND: begin
                o_ready     = i_mod_idle;
                o_cmd.clear = i_mod_idle;
                o_mod_start = i_mod_idle;
            end
            default: ;
        endcase
        w_accept        = i_valid && o_ready;
        o_cmd.load_byte = w_accept;
    end

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_final = r_final;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_SUM;
            S_SUM: begin
                if (r_final) begin
                    n_state = S_HAND;
                end else if (r_last) begin
                    n_state = S_LO;
                    n_final = 1'b1;
                end else if (w_accept) begin
                    n_state = S_LO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HAND: if (i_mod_idle) n_state = w_accept ? S_LO : S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_accept) begin
            n_last  = i_last_byte;
            n_final = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_final <= n_final;
        end
    end

endmodule
`default_nettype wire

// ----- design/mxbh_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mxbh_dp: running value datapath
// one shared 32x32 multiplier builds the 64-bit product in two halves,
// then one add and xorshift update the running value
// ----------------------------------------------------------------------------
module mxbh_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mxbh_pkg::t_dp_cmd              i_cmd,
    input  logic [mxbh_pkg::DATA_W-1:0]    i_data_byte,
    input  logic [mxbh_pkg::MULT_W-1:0]    i_multiplier,
    input  logic [mxbh_pkg::BITS_W-1:0]    i_bit_count,
    output logic [mxbh_pkg::VALUE_W-1:0]   o_value
);
    import mxbh_pkg::*;

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] r_plo;
    logic [HALF_W-1:0]  r_phi;
    logic [DATA_W-1:0]  r_byte;

    logic [HALF_W-1:0]  w_mul_a;
    logic [VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0] w_sum;
    logic [BITS_W-1:0]  w_amt;

    assign w_mul_a = i_cmd.mul_hi ? r_acc[VALUE_W-1:HALF_W] : r_acc[HALF_W-1:0];
    assign w_prod  = VALUE_W'(w_mul_a) * VALUE_W'(i_multiplier);

    // byte only enters on the per-byte pass
    assign w_sum = r_plo + {r_phi, {HALF_W{1'b0}}}
                 + (i_cmd.sum_first ? VALUE_W'(r_byte) : '0);
    assign w_amt = i_cmd.sum_first ? half_shift(i_bit_count) : final_shift(i_bit_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) r_byte <= i_data_byte;
        if (i_cmd.mul_lo)    r_plo  <= w_prod;
        if (i_cmd.mul_hi)    r_phi  <= w_prod[HALF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.clear) begin
            r_acc <= '0;
        end else if (i_cmd.sum_first || i_cmd.sum_final) begin
            r_acc <= xorshift(w_sum, w_amt);
        end
    end

    assign o_value = r_acc;

endmodule
`default_nettype wire

// ----- design/mxbh_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mxbh_mod: remainder unit and result register
// restoring remainder, one dividend bit a cycle, then the result word waits
// in an output register while the next message is hashed
// ----------------------------------------------------------------------------
module mxbh_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mxbh_pkg::VALUE_W-1:0]   i_value,
    input  logic [mxbh_pkg::TSIZE_W-1:0]   i_divisor,
    output logic                           o_idle,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mxbh_pkg::INDEX_W-1:0]   o_bucket_index
);
    import mxbh_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [VALUE_W-1:0]   r_quo;
    logic [TSIZE_W-1:0]   r_rem;
    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_out;

    logic [TSIZE_W:0]     w_trial;
    logic [TSIZE_W:0]     w_diff;
    logic                 w_ge;
    logic                 w_load_out;

    assign w_trial = {r_rem, r_quo[VALUE_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    // finished remainder moves on once the result register is free or emptying
    assign w_load_out = r_done && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_value;
                // zero table size: no reduction
                if (i_divisor == '0) begin
                    r_rem  <= i_value[TSIZE_W-1:0];
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= '0;
                    r_done <= 1'b0;
                end
            end else if (r_busy && !r_done) begin
                r_rem <= w_ge ? w_diff[TSIZE_W-1:0] : w_trial[TSIZE_W-1:0];
                r_quo <= {r_quo[VALUE_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) r_done <= 1'b1;
            end else if (w_load_out) begin
                r_out  <= r_rem[INDEX_W-1:0];
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end
        end
    end

    assign o_idle         = !r_busy;
    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out;

endmodule
`default_nettype wire

// ----- design/multiplicative_xorshift_byte_hash.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multiplicative_xorshift_byte_hash: byte-stream hash to bucket index
// keeps a 64-bit running value, w = v*mult + byte and v = w ^ shifted w per byte,
// and on the last byte one more multiply and xorshift, reduced modulo
// the table size into a bucket index
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+------------------------------
//  byte in   | in        | i_valid / o_ready  | i_data_byte, i_last_byte
//  bucket out| out       | o_valid / i_ready  | o_bucket_index
//  config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
//  a byte steps through low half product, high half product, add and
//  xorshift, the products through one shared 32x32 multiplier; the next
//  byte is taken in the add step
//  a last byte then repeats the product and add steps for the final
//  multiply, then a hand-over step, which can also take the first byte of
//  the next message; the remainder unit then runs in the background, 64
//  shift steps and one load of the result register (only the load when table
//  size is zero); a further last byte waits at hand-over until it is free
//  synchronous active-low reset clears the running value and restores the
//  register defaults; a stalled result word holds in the output register
// ----------------------------------------------------------------------------
module multiplicative_xorshift_byte_hash (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mxbh_pkg::DATA_W-1:0]       i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mxbh_pkg::INDEX_W-1:0]      o_bucket_index,
    input  logic                              i_cfg_we,
    input  logic [mxbh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mxbh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mxbh_pkg::*;

    // configuration registers
    logic [TSIZE_W-1:0] r_table_size;
    logic [MULT_W-1:0]  r_multiplier;
    logic [BITS_W-1:0]  r_bit_count;

    t_dp_cmd            w_cmd;
    logic               w_mod_start;
    logic               w_mod_idle;
    logic [VALUE_W-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TSIZE_RST;
            r_multiplier <= MULT_RST;
            r_bit_count  <= BITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_TABLE_SIZE: r_table_size <= i_cfg_data[TSIZE_W-1:0];
                CFG_IDX_MULTIPLIER: r_multiplier <= i_cfg_data[MULT_W-1:0];
                CFG_IDX_BIT_COUNT:  r_bit_count  <= i_cfg_data[BITS_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // sequencer: byte steps, final pass, hand-over
    mxbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_byte (i_last_byte),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd),
        .o_mod_start (w_mod_start),
        .i_mod_idle  (w_mod_idle)
    );

    // running value, shared multiplier, add and xorshift
    mxbh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_data_byte  (i_data_byte),
        .i_multiplier (r_multiplier),
        .i_bit_count  (r_bit_count),
        .o_value      (w_value)
    );

    // modulo table size and result register
    mxbh_mod u_mod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_mod_start),
        .i_value        (w_value),
        .i_divisor      (r_table_size),
        .o_idle         (w_mod_idle),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bucket_index (o_bucket_index)
    );

endmodule
`default_nettype wire

// ----- design/mxbh_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mxbh_chk: port-level checks of the byte hash
// reset state, gap after each accepted word and a held result word
// ----------------------------------------------------------------------------
module mxbh_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [mxbh_pkg::INDEX_W-1:0]  o_bucket_index
);

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("mxbh: bad state after reset");

    // every accepted word is followed by a multiply step with the input closed
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("mxbh: word accepted in back-to-back cycles");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bucket_index)))
        else $error("mxbh: result word dropped or changed under stall");

endmodule

bind multiplicative_xorshift_byte_hash mxbh_chk u_mxbh_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_bucket_index (o_bucket_index)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multiplicative xorshift byte hash
// drives message bytes through the valid/ready input, predicts every bucket
// index with an in-bench copy of the hash and compares it with each word
// taken from the output, under random idling, a long output stall and a
// spread of register settings including their extremes
// ----------------------------------------------------------------------------
module tb_top;
    import mxbh_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    // byte pipeline, final multiply, hand-over and the remainder unit
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RUN_LIMIT     = 5_000_000;
    localparam int PHASES        = 12;
    localparam int PHASE_BYTES   = 55;
    localparam int FLOOD_MSGS    = 30;

    // the fourth register index has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [DATA_W-1:0]     i_data_byte    = '0;
    logic                  i_last_byte    = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [INDEX_W-1:0]    o_bucket_index;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // shadow of the block: registers and running value
    logic [TSIZE_W-1:0]    tbl_size   = TSIZE_RST;
    logic [MULT_W-1:0]     hash_mult  = MULT_RST;
    logic [BITS_W-1:0]     shift_bits = BITS_RST;
    logic [VALUE_W-1:0]    hash_acc   = '0;

    // bucket indexes still owed by the block, oldest first
    logic [INDEX_W-1:0]    pending_buckets[$];

    int mismatches   = 0;
    bit tx_idle      = 1'b0;
    bit rx_idle      = 1'b0;
    int rx_hold_len  = 0;
    int rx_hold_left = 0;
    int rx_stall     = 0;

    multiplicative_xorshift_byte_hash u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bucket_index (o_bucket_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    // fold one accepted byte into the shadow hash, queue a bucket on the last one
    function automatic void hash_absorb(input logic [DATA_W-1:0] data, input logic last);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] rem;
        int                 amount;
        v = hash_acc * VALUE_W'(hash_mult) + VALUE_W'(data);
        amount = int'(shift_bits) / 2;
        // a shift of zero xors the value with itself and clears it
        v = v ^ (v >> amount);
        if (!last) begin
            hash_acc = v;
            return;
        end
        v = v * VALUE_W'(hash_mult);
        amount = int'(shift_bits) - int'(shift_bits) / 3;
        v = v ^ (v >> amount);
        // table size zero means no reduction at all
        rem = (tbl_size == '0) ? v : v % VALUE_W'(tbl_size);
        pending_buckets = {pending_buckets, rem[INDEX_W-1:0]};
        hash_acc = '0;
    endfunction

    // one register write; the enable drops in the step after the write edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_IDX_TABLE_SIZE: tbl_size   = data[TSIZE_W-1:0];
            CFG_IDX_MULTIPLIER: hash_mult  = data[MULT_W-1:0];
            CFG_IDX_BIT_COUNT:  shift_bits = data[BITS_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] tsize,
                              input logic [CFG_DATA_W-1:0] mult,
                              input logic [CFG_DATA_W-1:0] bits);
        cfg_write(CFG_IDX_TABLE_SIZE, tsize);
        cfg_write(CFG_IDX_MULTIPLIER, mult);
        cfg_write(CFG_IDX_BIT_COUNT, bits);
    endtask

    // offer one byte, hold it until taken, then predict
    task automatic send_byte(input logic [DATA_W-1:0] data, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        hash_absorb(data, last);
    endtask

    // stop offering, let every owed word arrive, then give the back stage time
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_buckets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // output side: per-word random stall, or a long hold when one is asked for
    always @(posedge i_clk) begin : rx_drive
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_len > 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
            i_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= (rx_hold_left == 0);
        end else if (o_valid && i_ready) begin
            rx_stall = rx_idle ? $urandom_range(0, 3) : 0;
            i_ready <= (rx_stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= (rx_stall == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every word taken is checked against the oldest owed bucket
    always @(posedge i_clk) begin : bucket_check
        logic [INDEX_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_buckets.size() == 0) begin
                report_mismatch($sformatf("bucket word %0d with none owed", o_bucket_index));
            end else begin
                want = pending_buckets.pop_front();
                if (o_bucket_index !== want)
                    report_mismatch($sformatf("bucket_index got %0d, want %0d",
                                              o_bucket_index, want));
            end
        end
    end

    // registers at their reset values, byte extremes
    task automatic test_reset_values();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'hAB, 1'b1);
        settle();
    endtask

    // register extremes, zero shifts, out-of-range bit counts, odd table sizes
    task automatic test_register_extremes();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // zero bit count: both xorshifts clear, largest table size
        set_config(33'h1_FFFF_FFFF, 33'h0_FFFF_FFFF, 33'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();
        // table size zero, top data bits ignored, bit count 63
        set_config(33'h0, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        settle();
        // table size one, half shift of zero
        set_config(33'd1, 33'd631, 33'd1);
        send_byte(8'h5A, 1'b1);
        settle();
        // table of two to the 32, multiplier zero
        set_config(33'h1_0000_0000, 33'd0, 33'd32);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
        settle();
        // smallest legal table, unit multiplier, bit count past the range
        set_config(33'd2, 33'd1, 33'd40);
        send_byte(8'hC3, 1'b1);
        settle();
        // write to the spare index must change nothing
        cfg_write(CFG_IDX_SPARE, 33'h1_FFFF_FFFF);
        send_byte(8'h7F, 1'b1);
        settle();
    endtask

    // phases of random messages, each under a fresh random setting
    task automatic test_random_messages();
        logic [CFG_DATA_W-1:0] tsize;
        logic [MULT_W-1:0]     mult;
        logic [BITS_W-1:0]     bits;
        int                    sent;
        int                    len;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: tsize = 33'h0;
                1: tsize = 33'd1;
                2: tsize = 33'h1_FFFF_FFFF;
                3: tsize = 33'h1_0000_0000;
                4: tsize = 33'd1 << $urandom_range(1, 32);
                5: tsize = {1'($urandom_range(0, 1)), 32'($urandom())};
                default: tsize = 33'($urandom_range(2, 5000));
            endcase
            case ($urandom_range(0, 5))
                0: mult = '0;
                1: mult = 32'hFFFF_FFFF;
                2: mult = 32'($urandom_range(1, 1000));
                default: mult = 32'($urandom());
            endcase
            bits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 32));
            // junk above the multiplier and bit count widths must be dropped
            set_config(tsize,
                       {1'($urandom_range(0, 1)), mult},
                       {27'($urandom()), bits});
            // some phases run flat out on one or both sides
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(10, 40);
                    1, 2:    len = 1;
                    default: len = $urandom_range(2, 6);
                endcase
                for (int k = 0; k < len; k++)
                    send_byte(8'($urandom_range(0, 255)), k == len - 1);
                sent += len;
            end
            settle();
        end
    endtask

    // output held off while single-byte messages keep coming, input must stall
    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (int k = 0; k < FLOOD_MSGS; k++)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        settle();
    endtask

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_register_extremes();
        test_random_messages();
        test_output_stall();
        if (pending_buckets.size() != 0)
            report_mismatch($sformatf("%0d bucket words never came", pending_buckets.size()));
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard
    initial begin : run_limit
        #RUN_LIMIT;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
